@@ rtl/rrch_pkg.sv @@
// Shared constants, types and the ring radius table of the radial ring
// class histogram unit. No dependencies; every other file refers to it.
package rrch_pkg;

    // Sizes of the histogram
    localparam int MAX_CLASSES = 8;
    localparam int NUM_RINGS   = 14;
    localparam int ACC_WIDTH   = 48;
    localparam int COORD_BITS  = 12;
    localparam int TABLE_RINGS = 14;

    // Fixed field widths of the ports
    localparam int CMD_BITS       = 2;
    localparam int COORD_IN_BITS  = 12;
    localparam int CLS_IN_BITS    = 3;
    localparam int WEIGHT_BITS    = 16;
    localparam int BIN_BITS       = 4;
    localparam int TOTAL_BITS     = 48;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int POS_BITS       = 16;   // Q12.4 coordinate

    // Store layout: one row of slots per class, slot 0 is the disc total
    localparam int SLOT_BITS = $clog2(NUM_RINGS + 2);
    localparam int ROW_BITS  = $clog2(MAX_CLASSES);
    localparam int ADDR_BITS = ROW_BITS + SLOT_BITS;
    localparam int MEM_DEPTH = MAX_CLASSES << SLOT_BITS;
    localparam int RING_BITS = $clog2(NUM_RINGS + 1);

    // Threshold arithmetic widths
    localparam int MUL_BITS  = 17;              // shared multiplier operand
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int P_BITS    = 33;              // ring coefficient times radius
    localparam int SQ_BITS   = 2 * P_BITS;      // square of that
    localparam int THR_BITS  = 35;              // ceil(square / 2^32)
    localparam int DIST_BITS = 33;              // squared distance
    localparam int DSQ_BITS  = 2 * POS_BITS;    // square of the disc radius

    localparam logic [ACC_WIDTH-1:0] ACC_MAX    = '1;
    localparam logic [SLOT_BITS-1:0] SLOT_DISC  = '0;
    localparam logic [SLOT_BITS-1:0] SLOT_OTHER = SLOT_BITS'(NUM_RINGS + 1);

    // Command codes of the input word
    localparam logic [CMD_BITS-1:0] CMD_ACC   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISC_RADIUS = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHTED    = 2'd3;

    // Ring radii as fractions of the disc radius, unsigned Q1.16
    localparam logic [MUL_BITS-1:0] RING_Q16 [TABLE_RINGS] = '{
        17'd4588,  17'd10486, 17'd16384, 17'd22938, 17'd29491, 17'd36045,
        17'd42598, 17'd49152, 17'd55706, 17'd62259, 17'd68813, 17'd75366,
        17'd81920, 17'd88474
    };

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_R2,
        OP_P,
        OP_PLL,
        OP_PHL,
        OP_PHH,
        OP_SUMP,
        OP_CEIL,
        OP_DIFF,
        OP_SQX,
        OP_SQY,
        OP_DIST,
        OP_CMP,
        OP_ENC,
        OP_DISC,
        OP_RING,
        OP_RDADDR,
        OP_RDOUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic cap;      // capture the input word
        logic clr;      // drop every accumulator
    } t_dp_cmd;

    typedef struct packed {
        logic rad_wr;    // disc radius written this cycle
        logic ring_last; // ring counter on the last ring
    } t_dp_stat;

    // Ring coefficient; rings past the table have radius zero
    function automatic logic [MUL_BITS-1:0] ring_coef(input logic [RING_BITS-1:0] idx);
        logic [MUL_BITS-1:0] c;
        c = '0;
        for (int k = 0; k < TABLE_RINGS; k++) begin
            if (32'(idx) == k) begin
                c = RING_Q16[k];
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/radial_ring_class_histogram_unit.sv @@
// Top level of the radial ring class histogram unit: joins the sequencer
// and the datapath. Depends on rrch_pkg, rrch_ctrl and rrch_dp.
//
// Takes one word at a time. An accumulate word occupies the block until it is
// done: the distance is squared on a single shared 17x17 multiplier, compared
// against all ring thresholds, then the disc slot and the ring slot are each
// read and written back in turn on the store's one read and one write port.
// A read word addresses the store, then waits for the output register to empty;
// a clear word returns straight to idle. After reset and after every write of
// disc_radius, ready stays low while the disc radius is squared and the shared
// multiplier builds the squared ring thresholds, six steps per ring.
// Accumulators are 48 bits, saturate at full scale, and are cleared at once by
// reset or by a clear word.
module radial_ring_class_histogram_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rrch_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rrch_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rrch_pkg::CMD_BITS-1:0]       i_command,
    input  logic [rrch_pkg::COORD_IN_BITS-1:0]  i_pix_x,
    input  logic [rrch_pkg::COORD_IN_BITS-1:0]  i_pix_y,
    input  logic [rrch_pkg::CLS_IN_BITS-1:0]    i_class_index,
    input  logic [rrch_pkg::WEIGHT_BITS-1:0]    i_weight,
    input  logic [rrch_pkg::BIN_BITS-1:0]       i_read_bin,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rrch_pkg::TOTAL_BITS-1:0]     o_total,
    output logic                                o_saturated
);

    rrch_pkg::t_dp_cmd  dp_cmd;
    rrch_pkg::t_dp_stat dp_stat;

    rrch_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_ready   (i_ready),
        .i_stat    (dp_stat),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_cmd     (dp_cmd)
    );

    rrch_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pix_x       (i_pix_x),
        .i_pix_y       (i_pix_y),
        .i_class_index (i_class_index),
        .i_weight      (i_weight),
        .i_read_bin    (i_read_bin),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_total       (o_total),
        .o_saturated   (o_saturated)
    );

endmodule

@@ rtl/rrch_ctrl.sv @@
// Sequencer of the radial ring class histogram unit: threshold setup,
// pixel accumulate, read and clear. Depends on rrch_pkg.
module rrch_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_command,
    input  logic               i_ready,
    input  rrch_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output logic               o_valid,
    output rrch_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_SU_R2   = 18'h00002,
        ST_SU_P    = 18'h00004,
        ST_SU_LL   = 18'h00008,
        ST_SU_HL   = 18'h00010,
        ST_SU_HH   = 18'h00020,
        ST_SU_SUM  = 18'h00040,
        ST_SU_CEIL = 18'h00080,
        ST_PX_DIFF = 18'h00100,
        ST_PX_SQX  = 18'h00200,
        ST_PX_SQY  = 18'h00400,
        ST_PX_DIST = 18'h00800,
        ST_PX_CMP  = 18'h01000,
        ST_PX_ENC  = 18'h02000,
        ST_PX_DISC = 18'h04000,
        ST_PX_RING = 18'h08000,
        ST_RD_ADDR = 18'h10000,
        ST_RD_OUT  = 18'h20000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_ready  = (r_state == ST_IDLE) && !i_stat.rad_wr;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;

    // Next state and datapath operation
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = rrch_pkg::OP_NONE;
        o_cmd.cap = accept;
        o_cmd.clr = accept && (i_command == rrch_pkg::CMD_CLEAR);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        rrch_pkg::CMD_ACC:  n_state = ST_PX_DIFF;
                        rrch_pkg::CMD_READ: n_state = ST_RD_ADDR;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SU_R2: begin
                o_cmd.op = rrch_pkg::OP_R2;
                n_state  = ST_SU_P;
            end
            ST_SU_P: begin
                o_cmd.op = rrch_pkg::OP_P;
                n_state  = ST_SU_LL;
            end
            ST_SU_LL: begin
                o_cmd.op = rrch_pkg::OP_PLL;
                n_state  = ST_SU_HL;
            end
            ST_SU_HL: begin
                o_cmd.op = rrch_pkg::OP_PHL;
                n_state  = ST_SU_HH;
            end
            ST_SU_HH: begin
                o_cmd.op = rrch_pkg::OP_PHH;
                n_state  = ST_SU_SUM;
            end
            ST_SU_SUM: begin
                o_cmd.op = rrch_pkg::OP_SUMP;
                n_state  = ST_SU_CEIL;
            end
            ST_SU_CEIL: begin
                o_cmd.op = rrch_pkg::OP_CEIL;
                n_state  = i_stat.ring_last ? ST_IDLE : ST_SU_P;
            end
            ST_PX_DIFF: begin
                o_cmd.op = rrch_pkg::OP_DIFF;
                n_state  = ST_PX_SQX;
            end
            ST_PX_SQX: begin
                o_cmd.op = rrch_pkg::OP_SQX;
                n_state  = ST_PX_SQY;
            end
            ST_PX_SQY: begin
                o_cmd.op = rrch_pkg::OP_SQY;
                n_state  = ST_PX_DIST;
            end
            ST_PX_DIST: begin
                o_cmd.op = rrch_pkg::OP_DIST;
                n_state  = ST_PX_CMP;
            end
            ST_PX_CMP: begin
                o_cmd.op = rrch_pkg::OP_CMP;
                n_state  = ST_PX_ENC;
            end
            ST_PX_ENC: begin
                o_cmd.op = rrch_pkg::OP_ENC;
                n_state  = ST_PX_DISC;
            end
            ST_PX_DISC: begin
                o_cmd.op = rrch_pkg::OP_DISC;
                n_state  = ST_PX_RING;
            end
            ST_PX_RING: begin
                o_cmd.op = rrch_pkg::OP_RING;
                n_state  = ST_IDLE;
            end
            ST_RD_ADDR: begin
                o_cmd.op = rrch_pkg::OP_RDADDR;
                n_state  = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.op = rrch_pkg::OP_RDOUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_SU_R2;
        endcase
        // a new disc radius restarts the threshold setup
        if (i_stat.rad_wr) begin
            n_state = ST_SU_R2;
        end
    end

    // Output word valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == ST_RD_OUT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SU_R2;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_read_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == rrch_pkg::CMD_READ)) |=> (r_state == ST_RD_ADDR))
        else $error("read word did not advance to the address step");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RD_OUT))
        else $error("output word raised outside the read output step");

    a_setup_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SU_CEIL) && i_stat.ring_last && !i_stat.rad_wr)
        |=> (r_state == ST_IDLE))
        else $error("threshold setup did not finish after the last ring");

endmodule

@@ rtl/rrch_dp.sv @@
// Datapath of the radial ring class histogram unit: configuration registers,
// ring thresholds, distance arithmetic and the accumulator store.
// Depends on rrch_pkg.
module rrch_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rrch_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rrch_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [rrch_pkg::COORD_IN_BITS-1:0]  i_pix_x,
    input  logic [rrch_pkg::COORD_IN_BITS-1:0]  i_pix_y,
    input  logic [rrch_pkg::CLS_IN_BITS-1:0]    i_class_index,
    input  logic [rrch_pkg::WEIGHT_BITS-1:0]    i_weight,
    input  logic [rrch_pkg::BIN_BITS-1:0]       i_read_bin,
    input  rrch_pkg::t_dp_cmd                   i_cmd,
    output rrch_pkg::t_dp_stat                  o_stat,
    output logic [rrch_pkg::TOTAL_BITS-1:0]     o_total,
    output logic                                o_saturated
);

    localparam logic [rrch_pkg::COORD_IN_BITS-1:0] COORD_MASK =
        rrch_pkg::COORD_IN_BITS'((64'd1 << rrch_pkg::COORD_BITS) - 64'd1);
    localparam int SHIFT_MID = rrch_pkg::MUL_BITS + 1;
    localparam int SHIFT_HI  = 2 * rrch_pkg::MUL_BITS;

    function automatic logic [rrch_pkg::ADDR_BITS-1:0] mem_addr(
        input logic [rrch_pkg::CLS_IN_BITS-1:0] cls,
        input logic [rrch_pkg::SLOT_BITS-1:0]   slot
    );
        return (rrch_pkg::ADDR_BITS'(cls) << rrch_pkg::SLOT_BITS)
               | rrch_pkg::ADDR_BITS'(slot);
    endfunction

    // Configuration
    logic [rrch_pkg::POS_BITS-1:0] r_cx, r_cy, r_rad;
    logic                          r_wmode;

    // Captured input word
    logic [rrch_pkg::COORD_IN_BITS-1:0] r_px, r_py;
    logic [rrch_pkg::CLS_IN_BITS-1:0]   r_cls;
    logic                               r_cls_ok;
    logic [rrch_pkg::WEIGHT_BITS-1:0]   r_wt;
    logic [rrch_pkg::BIN_BITS-1:0]      r_bin;

    // Threshold setup
    logic [rrch_pkg::RING_BITS-1:0] r_ring;
    logic [rrch_pkg::P_BITS-1:0]    r_p;
    logic [rrch_pkg::PROD_BITS-1:0] r_prod;
    logic [rrch_pkg::SQ_BITS-1:0]   r_acc;
    logic [rrch_pkg::THR_BITS-1:0]  r_thr [rrch_pkg::NUM_RINGS];
    logic [rrch_pkg::DSQ_BITS-1:0]  r_disc_sq;

    // Pixel path
    logic [rrch_pkg::POS_BITS-1:0]  r_dx, r_dy;
    logic [rrch_pkg::DIST_BITS-1:0] r_dist2;
    logic [rrch_pkg::NUM_RINGS-1:0] r_lt;
    logic                           r_in_disc;
    logic [rrch_pkg::SLOT_BITS-1:0] r_slot;

    // Store
    logic [rrch_pkg::ACC_WIDTH-1:0] mem [rrch_pkg::MEM_DEPTH];
    logic [rrch_pkg::MEM_DEPTH-1:0] r_valid;
    logic [rrch_pkg::ACC_WIDTH-1:0] r_rdata;
    logic                           r_rvalid;
    logic                           r_rd_ok;

    // Output word
    logic [rrch_pkg::TOTAL_BITS-1:0] r_total;
    logic                            r_sat;

    logic [rrch_pkg::MUL_BITS-1:0]  mul_a, mul_b;
    logic [rrch_pkg::PROD_BITS-1:0] prod;
    logic [rrch_pkg::MUL_BITS-1:0]  p_lo, p_hi;
    logic [rrch_pkg::POS_BITS-1:0]  px_q, py_q;
    logic [rrch_pkg::THR_BITS-1:0]  thr_next;
    logic [rrch_pkg::SLOT_BITS-1:0] slot_next;
    logic [rrch_pkg::ACC_WIDTH-1:0] old_val, inc_val, new_val, rd_val;
    logic [rrch_pkg::ACC_WIDTH:0]   sum_val;
    logic                           mem_we, mem_re;
    logic [rrch_pkg::ADDR_BITS-1:0] mem_waddr, mem_raddr;

    assign o_stat.rad_wr    = i_cfg_we && (i_cfg_index == rrch_pkg::CFG_DISC_RADIUS);
    assign o_stat.ring_last = (32'(r_ring) == rrch_pkg::NUM_RINGS - 1);
    assign o_total          = r_total;
    assign o_saturated      = r_sat;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= 16'd32768;
            r_cy    <= 16'd32768;
            r_rad   <= 16'd25600;
            r_wmode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rrch_pkg::CFG_CENTER_X:    r_cx    <= i_cfg_data;
                rrch_pkg::CFG_CENTER_Y:    r_cy    <= i_cfg_data;
                rrch_pkg::CFG_DISC_RADIUS: r_rad   <= i_cfg_data;
                rrch_pkg::CFG_WEIGHTED:    r_wmode <= i_cfg_data[0];
                default:                   r_wmode <= r_wmode;
            endcase
        end
    end

    // Shared multiplier operand select
    assign p_lo = r_p[rrch_pkg::MUL_BITS-1:0];
    assign p_hi = rrch_pkg::MUL_BITS'(r_p[rrch_pkg::P_BITS-1:rrch_pkg::MUL_BITS]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            rrch_pkg::OP_R2: begin
                mul_a = rrch_pkg::MUL_BITS'(r_rad);
                mul_b = rrch_pkg::MUL_BITS'(r_rad);
            end
            rrch_pkg::OP_P: begin
                mul_a = rrch_pkg::ring_coef(r_ring);
                mul_b = rrch_pkg::MUL_BITS'(r_rad);
            end
            rrch_pkg::OP_PLL: begin
                mul_a = p_lo;
                mul_b = p_lo;
            end
            rrch_pkg::OP_PHL: begin
                mul_a = p_hi;
                mul_b = p_lo;
            end
            rrch_pkg::OP_PHH: begin
                mul_a = p_hi;
                mul_b = p_hi;
            end
            rrch_pkg::OP_SQX: begin
                mul_a = rrch_pkg::MUL_BITS'(r_dx);
                mul_b = rrch_pkg::MUL_BITS'(r_dx);
            end
            rrch_pkg::OP_SQY: begin
                mul_a = rrch_pkg::MUL_BITS'(r_dy);
                mul_b = rrch_pkg::MUL_BITS'(r_dy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {{rrch_pkg::MUL_BITS{1'b0}}, mul_a} * {{rrch_pkg::MUL_BITS{1'b0}}, mul_b};

    // Threshold is ceil(p^2 / 2^32), so dist2 < thr matches dist2 * 2^32 < p^2
    assign thr_next = rrch_pkg::THR_BITS'(r_acc[rrch_pkg::SQ_BITS-1:32])
                    + rrch_pkg::THR_BITS'(|r_acc[31:0]);

    // Pixel position in Q12.4
    assign px_q = {r_px, 4'b0000};
    assign py_q = {r_py, 4'b0000};

    // First ring that holds the pixel, else the other bin
    always_comb begin
        slot_next = rrch_pkg::SLOT_OTHER;
        for (int k = rrch_pkg::NUM_RINGS - 1; k >= 0; k--) begin
            if (r_lt[k]) begin
                slot_next = rrch_pkg::SLOT_BITS'(k + 1);
            end
        end
    end

    // Saturating update of the value read last cycle
    assign old_val = r_rvalid ? r_rdata : '0;
    assign inc_val = r_wmode ? rrch_pkg::ACC_WIDTH'(r_wt) : rrch_pkg::ACC_WIDTH'(1);
    assign sum_val = {1'b0, old_val} + {1'b0, inc_val};
    assign new_val = sum_val[rrch_pkg::ACC_WIDTH] ? rrch_pkg::ACC_MAX
                                                  : sum_val[rrch_pkg::ACC_WIDTH-1:0];
    assign rd_val  = (r_rvalid && r_rd_ok) ? r_rdata : '0;

    // Store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = mem_addr(r_cls, r_slot);
        mem_raddr = mem_addr(r_cls, rrch_pkg::SLOT_DISC);
        case (i_cmd.op)
            rrch_pkg::OP_ENC: begin
                mem_re = 1'b1;
            end
            rrch_pkg::OP_DISC: begin
                mem_we    = r_in_disc && r_cls_ok;
                mem_waddr = mem_addr(r_cls, rrch_pkg::SLOT_DISC);
                mem_re    = 1'b1;
                mem_raddr = mem_addr(r_cls, r_slot);
            end
            rrch_pkg::OP_RING: begin
                mem_we = r_cls_ok;
            end
            rrch_pkg::OP_RDADDR: begin
                mem_re    = 1'b1;
                mem_raddr = mem_addr(r_cls, rrch_pkg::SLOT_BITS'(r_bin));
            end
            default: begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= new_val;
        end
        if (mem_re) begin
            r_rdata  <= mem[mem_raddr];
            r_rvalid <= r_valid[mem_raddr];
        end
    end

    // Entry valid bits: reset and clear drop every accumulator at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[mem_waddr] <= 1'b1;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_px     <= i_pix_x & COORD_MASK;
            r_py     <= i_pix_y & COORD_MASK;
            r_cls    <= i_class_index;
            r_cls_ok <= 32'(i_class_index) < rrch_pkg::MAX_CLASSES;
            r_wt     <= i_weight;
            r_bin    <= i_read_bin;
        end
    end

    // Arithmetic steps
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rrch_pkg::OP_R2: begin
                r_disc_sq <= prod[rrch_pkg::DSQ_BITS-1:0];
                r_ring    <= '0;
            end
            rrch_pkg::OP_P: begin
                r_p <= prod[rrch_pkg::P_BITS-1:0];
            end
            rrch_pkg::OP_PLL: begin
                r_prod <= prod;
            end
            rrch_pkg::OP_PHL: begin
                r_acc  <= rrch_pkg::SQ_BITS'(r_prod);
                r_prod <= prod;
            end
            rrch_pkg::OP_PHH: begin
                r_acc  <= r_acc + (rrch_pkg::SQ_BITS'(r_prod) << SHIFT_MID);
                r_prod <= prod;
            end
            rrch_pkg::OP_SUMP: begin
                r_acc <= r_acc + (rrch_pkg::SQ_BITS'(r_prod) << SHIFT_HI);
            end
            rrch_pkg::OP_CEIL: begin
                for (int k = 0; k < rrch_pkg::NUM_RINGS; k++) begin
                    if (32'(r_ring) == k) begin
                        r_thr[k] <= thr_next;
                    end
                end
                r_ring <= r_ring + 1'b1;
            end
            rrch_pkg::OP_DIFF: begin
                r_dx <= (px_q >= r_cx) ? px_q - r_cx : r_cx - px_q;
                r_dy <= (py_q >= r_cy) ? py_q - r_cy : r_cy - py_q;
            end
            rrch_pkg::OP_SQX: begin
                r_prod <= prod;
            end
            rrch_pkg::OP_SQY: begin
                r_dist2 <= rrch_pkg::DIST_BITS'(r_prod);
                r_prod  <= prod;
            end
            rrch_pkg::OP_DIST: begin
                r_dist2 <= r_dist2 + rrch_pkg::DIST_BITS'(r_prod);
            end
            rrch_pkg::OP_CMP: begin
                for (int k = 0; k < rrch_pkg::NUM_RINGS; k++) begin
                    r_lt[k] <= {2'b00, r_dist2} < r_thr[k];
                end
                r_in_disc <= r_dist2 < {1'b0, r_disc_sq};
            end
            rrch_pkg::OP_ENC: begin
                r_slot <= slot_next;
            end
            rrch_pkg::OP_RDADDR: begin
                r_rd_ok <= r_cls_ok && (32'(r_bin) <= rrch_pkg::NUM_RINGS + 1);
            end
            rrch_pkg::OP_RDOUT: begin
                r_total <= rrch_pkg::TOTAL_BITS'(rd_val);
                r_sat   <= (rd_val == rrch_pkg::ACC_MAX);
            end
            default: begin
                r_ring <= r_ring;
            end
        endcase
    end

    a_write_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_cls_ok)
        else $error("store written for a class row that is not present");

    a_ring_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rrch_pkg::OP_RING) |-> (r_slot != rrch_pkg::SLOT_DISC))
        else $error("ring update aimed at the disc slot");

endmodule

@@ verif/radial_ring_class_histogram_unit_tb.sv @@
// Self-checking testbench for the radial ring class histogram unit: random
// pixel, read and clear words against a built-in histogram predictor.
// Depends on rrch_pkg and radial_ring_class_histogram_unit.
module radial_ring_class_histogram_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rrch_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    // Ring radii as fractions of the disc radius, unsigned Q1.16
    localparam int unsigned RING_FRAC_Q16 [14] = '{
        4588, 10486, 16384, 22938, 29491, 36045, 42598,
        49152, 55706, 62259, 68813, 75366, 81920, 88474
    };

    typedef struct packed {
        logic [rrch_pkg::CMD_BITS-1:0]      command;
        logic [rrch_pkg::COORD_IN_BITS-1:0] pix_x;
        logic [rrch_pkg::COORD_IN_BITS-1:0] pix_y;
        logic [rrch_pkg::CLS_IN_BITS-1:0]   class_index;
        logic [rrch_pkg::WEIGHT_BITS-1:0]   weight;
        logic [rrch_pkg::BIN_BITS-1:0]      read_bin;
    } t_pixel_word;

    typedef struct packed {
        logic [rrch_pkg::TOTAL_BITS-1:0] total;
        logic                            saturated;
    } t_bin_total;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                cfg_we = 1'b0;
    logic [rrch_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [rrch_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    t_pixel_word held_word = '0;

    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [rrch_pkg::TOTAL_BITS-1:0] out_total;
    logic                            out_saturated;

    // Stimulus and expectation stores
    t_pixel_word pixel_words [$];
    t_bin_total  expected_reads [$];
    int          send_gap = 0;
    int          stall_left = 0;
    bit          quiet_phase = 1'b0;
    int          mismatches = 0;

    // Predictor state: configuration mirror and accumulators
    logic [15:0]                    cur_cx = 16'd32768;
    logic [15:0]                    cur_cy = 16'd32768;
    logic [15:0]                    cur_radius = 16'd25600;
    logic                           cur_weighted = 1'b0;
    logic [rrch_pkg::ACC_WIDTH-1:0] ring_acc [rrch_pkg::MAX_CLASSES][rrch_pkg::NUM_RINGS+1];
    logic [rrch_pkg::ACC_WIDTH-1:0] disc_acc [rrch_pkg::MAX_CLASSES];

    radial_ring_class_histogram_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_command     (held_word.command),
        .i_pix_x       (held_word.pix_x),
        .i_pix_y       (held_word.pix_y),
        .i_class_index (held_word.class_index),
        .i_weight      (held_word.weight),
        .i_read_bin    (held_word.read_bin),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_total       (out_total),
        .o_saturated   (out_saturated)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones, none in a quiet phase
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rrch_pkg::ACC_WIDTH-1:0] sat_sum(
        input logic [rrch_pkg::ACC_WIDTH-1:0] acc,
        input logic [rrch_pkg::ACC_WIDTH-1:0] inc
    );
        logic [rrch_pkg::ACC_WIDTH:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        return s[rrch_pkg::ACC_WIDTH] ? rrch_pkg::ACC_MAX : s[rrch_pkg::ACC_WIDTH-1:0];
    endfunction

    function automatic void clear_histogram();
        for (int c = 0; c < rrch_pkg::MAX_CLASSES; c++) begin
            disc_acc[c] = '0;
            for (int b = 0; b <= rrch_pkg::NUM_RINGS; b++) ring_acc[c][b] = '0;
        end
    endfunction

    // Apply one accepted word to the histogram; queue the result of a read
    function automatic void update_histogram(input t_pixel_word w);
        logic [127:0]                   px, py, dx, dy, dist2, rad, p;
        logic [rrch_pkg::ACC_WIDTH-1:0] inc, v;
        int                             hit, cls, bin;
        t_bin_total                     res;
        cls = int'(w.class_index);
        bin = int'(w.read_bin);
        case (w.command)
            rrch_pkg::CMD_ACC: begin
                if (cls < rrch_pkg::MAX_CLASSES) begin
                    px = 128'(w.pix_x) << 4;
                    py = 128'(w.pix_y) << 4;
                    dx = (px >= 128'(cur_cx)) ? px - 128'(cur_cx) : 128'(cur_cx) - px;
                    dy = (py >= 128'(cur_cy)) ? py - 128'(cur_cy) : 128'(cur_cy) - py;
                    dist2 = dx * dx + dy * dy;
                    rad = 128'(cur_radius);
                    inc = cur_weighted ? rrch_pkg::ACC_WIDTH'(w.weight)
                                       : rrch_pkg::ACC_WIDTH'(1);
                    if (dist2 < rad * rad) disc_acc[cls] = sat_sum(disc_acc[cls], inc);
                    // first ring whose scaled radius exceeds the distance
                    hit = rrch_pkg::NUM_RINGS;
                    for (int r = 0; r < rrch_pkg::NUM_RINGS && r < 14; r++) begin
                        p = 128'(RING_FRAC_Q16[r]) * rad;
                        if (hit == rrch_pkg::NUM_RINGS && (dist2 << 32) < p * p) hit = r;
                    end
                    ring_acc[cls][hit] = sat_sum(ring_acc[cls][hit], inc);
                end
            end
            rrch_pkg::CMD_READ: begin
                v = '0;
                if (cls < rrch_pkg::MAX_CLASSES) begin
                    if (bin == 0) v = disc_acc[cls];
                    else if (bin <= rrch_pkg::NUM_RINGS + 1) v = ring_acc[cls][bin-1];
                end
                res.total = v;
                res.saturated = (v == rrch_pkg::ACC_MAX);
                expected_reads.insert(expected_reads.size(), res);
            end
            rrch_pkg::CMD_CLEAR: clear_histogram();
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic [rrch_pkg::TOTAL_BITS-1:0] want,
                                            input logic [rrch_pkg::TOTAL_BITS-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
    endfunction

    // Driver: hold the word until accepted, then advance after a random gap
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) update_histogram(held_word);
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (pixel_words.size() > 0) begin
                held_word <= pixel_words.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            out_ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk) begin
        t_bin_total want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("unexpected word total", '0, out_total);
            end else begin
                want = expected_reads.pop_front();
                if (out_total !== want.total)
                    report_mismatch("total", want.total, out_total);
                if (out_saturated !== want.saturated)
                    report_mismatch("saturated", rrch_pkg::TOTAL_BITS'(want.saturated),
                                    rrch_pkg::TOTAL_BITS'(out_saturated));
            end
        end
    end

    task automatic add_word(input logic [rrch_pkg::CMD_BITS-1:0] cmd, input int x,
                            input int y, input int cls, input int w, input int bin);
        t_pixel_word pw;
        pw.command = cmd;
        pw.pix_x = rrch_pkg::COORD_IN_BITS'(x);
        pw.pix_y = rrch_pkg::COORD_IN_BITS'(y);
        pw.class_index = rrch_pkg::CLS_IN_BITS'(cls);
        pw.weight = rrch_pkg::WEIGHT_BITS'(w);
        pw.read_bin = rrch_pkg::BIN_BITS'(bin);
        pixel_words.insert(pixel_words.size(), pw);
    endtask

    // Pixel coordinate around the disc, out to half again its radius
    function automatic int near_coord(input logic [15:0] ctr);
        int span, v, r;
        span = int'(cur_radius >> 4) * 3 / 2 + 1;
        r = int'($urandom_range(0, 2 * span));
        v = int'(ctr >> 4) + r - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    task automatic add_random_words(input int count);
        int r, x, y, w;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                if ($urandom_range(0, 9) < 7) begin
                    x = near_coord(cur_cx);
                    y = near_coord(cur_cy);
                end else begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                w = $urandom_range(0, 9);
                w = (w == 0) ? 0 : (w == 1) ? 65535 : $urandom_range(0, 65535);
                add_word(rrch_pkg::CMD_ACC, x, y, $urandom_range(0, 7), w,
                         $urandom_range(0, 15));
            end else if (r < 94) begin
                add_word(rrch_pkg::CMD_READ, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15));
            end else if (r < 97) begin
                add_word(rrch_pkg::CMD_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15));
            end else begin
                add_word(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 15));
            end
        end
    endtask

    // Wait until every word is sent and every read returned, then let an
    // accumulate still in flight finish
    task automatic drain_block();
        @(negedge clk);
        while (pixel_words.size() != 0 || in_valid || expected_reads.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rrch_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            rrch_pkg::CFG_CENTER_X:    cur_cx = val;
            rrch_pkg::CFG_CENTER_Y:    cur_cy = val;
            rrch_pkg::CFG_DISC_RADIUS: cur_radius = val;
            rrch_pkg::CFG_WEIGHTED:    cur_weighted = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] rad, input logic wm);
        drain_block();
        quiet_phase = ($urandom_range(0, 3) == 0);
        write_reg(rrch_pkg::CFG_CENTER_X, cx);
        write_reg(rrch_pkg::CFG_CENTER_Y, cy);
        write_reg(rrch_pkg::CFG_DISC_RADIUS, rad);
        write_reg(rrch_pkg::CFG_WEIGHTED, {15'd0, wm});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        clear_histogram();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the threshold build after reset is done
        @(negedge clk);
        while (!in_ready) @(negedge clk);

        // Default disc: reads at reset, centre, ring and disc edges, corners
        set_config(16'd32768, 16'd32768, 16'd25600, 1'b0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 0, 0, 0);
        add_word(rrch_pkg::CMD_READ, 4095, 4095, 7, 65535, 15);
        add_word(rrch_pkg::CMD_ACC, 2048, 2048, 0, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 2159, 2048, 0, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 2448, 2048, 1, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 3648, 2048, 2, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 0, 0, 7, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 4095, 4095, 3, 65535, 15);
        add_word(rrch_pkg::CMD_ACC, 2048, 0, 4, 0, 0);
        add_word(CMD_UNUSED, 4095, 4095, 7, 65535, 15);
        add_word(rrch_pkg::CMD_READ, 0, 0, 0, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 0, 0, 1);
        add_word(rrch_pkg::CMD_READ, 0, 0, 1, 0, 4);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 11);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 12);
        add_word(rrch_pkg::CMD_READ, 0, 0, 7, 0, 15);
        add_word(rrch_pkg::CMD_READ, 0, 0, 3, 0, 15);
        add_word(rrch_pkg::CMD_READ, 0, 0, 4, 0, 14);

        // Weighted mode: full, zero and smallest weight, then clear
        set_config(16'd32768, 16'd32768, 16'd25600, 1'b1);
        add_word(rrch_pkg::CMD_ACC, 2048, 2048, 5, 65535, 0);
        add_word(rrch_pkg::CMD_ACC, 2048, 2048, 5, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 2048, 2048, 5, 1, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 5, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 5, 0, 1);
        add_word(rrch_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 5, 0, 1);
        add_word(rrch_pkg::CMD_READ, 0, 0, 0, 0, 1);

        // Centre at the origin, largest radius
        set_config(16'd0, 16'd0, 16'd65535, 1'b0);
        add_word(rrch_pkg::CMD_ACC, 4095, 4095, 6, 0, 0);
        add_word(rrch_pkg::CMD_ACC, 0, 0, 6, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 6, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 6, 0, 1);
        add_word(rrch_pkg::CMD_READ, 0, 0, 6, 0, 15);
        add_random_words(60);

        // Centre at the far corner, smallest radius
        set_config(16'd65535, 16'd65535, 16'd1, 1'b1);
        add_word(rrch_pkg::CMD_ACC, 4095, 4095, 1, 300, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 1, 0, 15);
        add_random_words(60);

        // Zero disc radius: everything lands in the outer bin
        set_config(16'd32768, 16'd32768, 16'd0, 1'b0);
        add_word(rrch_pkg::CMD_ACC, 2048, 2048, 2, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 0);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 1);
        add_word(rrch_pkg::CMD_READ, 0, 0, 2, 0, 15);
        add_random_words(40);

        // Random settings
        for (int ph = 0; ph < 7; ph++) begin
            set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(16, 16000)),
                       1'($urandom_range(0, 1)));
            add_random_words(55);
        end

        drain_block();
        if (mismatches == 0) begin
            $display("radial_ring_class_histogram_unit_tb passed");
        end else begin
            $display("radial_ring_class_histogram_unit_tb failed");
        end
        $finish;
    end

    // Time limit
    initial begin
        #1000000;
        $display("radial_ring_class_histogram_unit_tb failed");
        $finish;
    end

endmodule
